@@ src/base64_line_wrapping_encoder_assert.svh @@
// Assertion macros for the base64 line wrapping encoder.
// Expects signals named clock and reset in the including module.
`ifndef BASE64_LINE_WRAPPING_ENCODER_ASSERT_SVH
`define BASE64_LINE_WRAPPING_ENCODER_ASSERT_SVH

// same-cycle implication
`define B64LW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define B64LW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/b64lw_pkg.sv @@
// Shared types, character constants and symbol mapping for the base64 encoder.
// No dependencies.
`timescale 1ns / 1ps

package b64lw_pkg;

   localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
   localparam logic [7:0] PAD_CHAR      = 8'h3D;
   localparam logic [7:0] MIN_WIDTH     = 8'd4;
   localparam logic [7:0] WIDTH_DEFAULT = 8'd76;
   localparam int unsigned GROUP_CHARS  = 4;

   typedef struct packed {
      logic                                flush;
      logic [GROUP_CHARS-1:0][7:0]         syms;
   } job_type;

   function automatic logic [7:0] b64lw_sym(input logic [5:0] v);
      logic [7:0] r;
      r = 8'h2F;
      case (v) inside
         [6'd0:6'd25]:  r = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: r = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: r = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:         r = 8'h2B;
         default:       r = 8'h2F;
      endcase
      return r;
   endfunction

endpackage

@@ src/base64_line_wrapping_encoder.sv @@
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_cmd, req_data_byte, req_last_of_chunk
//   rsp     | out       | rsp_valid/rsp_stall | rsp_out_char, rsp_last_of_run
//   csr     | in        | csr_write_enable    | csr_write_data (line width)
// An item passes through the input register, then the sequencer sends one word
// per cycle while rsp_stall is low: four symbols plus any newlines for a completed
// group, one newline or none for an end of section, nothing for a held byte.
// The sequencer sets the pace; the input register can fill while it is busy.
// Reset is synchronous and clears all control state; line width returns to 76.
// rsp_stall holds the result register; req_stall rises when stage 1 cannot drain.
`timescale 1ns / 1ps

module base64_line_wrapping_encoder import b64lw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_of_chunk,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic [7:0] width_ff;
   logic [7:0] eff_width;
   logic       job_valid;
   logic       job_ready;
   job_type    job;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_DEFAULT;
      end else if (csr_write_enable) begin
         width_ff <= csr_write_data;
      end
   end

   assign eff_width = (width_ff < MIN_WIDTH) ? MIN_WIDTH : width_ff;

   b64lw_enc u_enc (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_last_of_chunk (req_last_of_chunk),
      .job_valid         (job_valid),
      .job               (job),
      .job_ready         (job_ready)
   );

   b64lw_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .eff_width       (eff_width),
      .job_valid       (job_valid),
      .job             (job),
      .job_ready       (job_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ src/b64lw_enc.sv @@
// Input register and byte grouping: collects bytes in threes, forms four symbols.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_enc import b64lw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic    req_last_of_chunk,
   output logic    job_valid,
   output job_type job,
   input  logic    job_ready
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_cmd_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;

   logic       push;
   logic       consume;
   logic       accept;
   logic [7:0] b0, b1, b2;
   logic [1:0] cnt;

   always_comb begin
      push          = 1'b1;
      b0            = held_bytes_ff[15:8];
      b1            = held_bytes_ff[7:0];
      b2            = s1_byte_ff;
      cnt           = 2'd3;
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      if (s1_cmd_ff) begin
         cnt = 2'd0;
      end else if (held_count_ff >= 2'd2) begin
         held_count_in = 2'd0;
      end else if (s1_last_ff) begin
         if (held_count_ff == 2'd0) begin
            b0  = s1_byte_ff;
            cnt = 2'd1;
         end else begin
            b1  = s1_byte_ff;
            cnt = 2'd2;
         end
         held_count_in = 2'd0;
      end else begin
         push = 1'b0;
         if (held_count_ff == 2'd0) begin
            held_bytes_in = {s1_byte_ff, 8'h00};
         end else begin
            held_bytes_in = {held_bytes_ff[15:8], s1_byte_ff};
         end
         held_count_in = held_count_ff + 2'd1;
      end
   end

   always_comb begin
      job.flush   = s1_cmd_ff;
      job.syms[0] = b64lw_sym(b0[7:2]);
      case (cnt)
         2'd1: begin
            job.syms[1] = b64lw_sym({b0[1:0], 4'h0});
            job.syms[2] = PAD_CHAR;
            job.syms[3] = PAD_CHAR;
         end
         2'd2: begin
            job.syms[1] = b64lw_sym({b0[1:0], b1[7:4]});
            job.syms[2] = b64lw_sym({b1[3:0], 2'b00});
            job.syms[3] = PAD_CHAR;
         end
         default: begin
            job.syms[1] = b64lw_sym({b0[1:0], b1[7:4]});
            job.syms[2] = b64lw_sym({b1[3:0], b2[7:6]});
            job.syms[3] = b64lw_sym(b2[5:0]);
         end
      endcase
   end

   assign job_valid   = s1_valid_ff && push;
   assign consume     = s1_valid_ff && (!push || job_ready);
   assign req_stall   = s1_valid_ff && !consume;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept ? 1'b1 : (consume ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         held_count_ff <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (consume) begin
            held_count_ff <= held_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_of_chunk;
      end
      if (consume) begin
         held_bytes_ff <= held_bytes_in;
      end
   end

endmodule

@@ src/b64lw_emit.sv @@
// Character sequencer and result register: one word per unstalled cycle, column
// tracking, newline insertion; needs b64lw_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "base64_line_wrapping_encoder_assert.svh"

module b64lw_emit import b64lw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] eff_width,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic       busy_ff, busy_in;
   job_type    job_ff;
   logic [1:0] idx_ff, idx_in;
   logic       nl_ff, nl_in;
   logic       nl_last_ff, nl_last_in;
   logic [7:0] column_ff, column_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       out_free;
   logic       advance;
   logic       emit;
   logic       done;
   logic       load;
   logic [7:0] col_inc;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = busy_ff && out_free;
   assign col_inc  = column_ff + 8'd1;

   always_comb begin
      emit        = 1'b1;
      done        = 1'b0;
      idx_in      = idx_ff;
      nl_in       = nl_ff;
      nl_last_in  = nl_last_ff;
      column_in   = column_ff;
      rsp_char_in = NEWLINE_CHAR;
      rsp_last_in = 1'b0;
      if (nl_ff) begin
         rsp_last_in = nl_last_ff;
         done        = nl_last_ff;
         nl_in       = 1'b0;
      end else if (job_ff.flush) begin
         emit        = (column_ff != 8'd0);
         rsp_last_in = 1'b1;
         done        = 1'b1;
         column_in   = 8'd0;
      end else begin
         rsp_char_in = job_ff.syms[idx_ff];
         idx_in      = idx_ff + 2'd1;
         if (col_inc >= eff_width) begin
            nl_in      = 1'b1;
            nl_last_in = (idx_ff == 2'd3);
            column_in  = 8'd0;
         end else begin
            column_in   = col_inc;
            rsp_last_in = (idx_ff == 2'd3);
            done        = (idx_ff == 2'd3);
         end
      end
   end

   assign job_ready    = !busy_ff || (advance && done);
   assign load         = job_valid && job_ready;
   assign busy_in      = load ? 1'b1 : ((advance && done) ? 1'b0 : busy_ff);
   assign rsp_valid_in = out_free ? (advance && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         nl_ff        <= 1'b0;
         nl_last_ff   <= 1'b0;
         column_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            nl_last_ff <= nl_last_in;
            column_ff  <= column_in;
         end
         if (load) begin
            idx_ff <= 2'd0;
            nl_ff  <= 1'b0;
         end else if (advance) begin
            idx_ff <= idx_in;
            nl_ff  <= nl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
      if (advance && emit) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `B64LW_ASSERT_NOW(a_nl_col_zero, busy_ff && nl_ff, column_ff == 8'd0, "column set at newline")
   `B64LW_ASSERT_NEXT(a_flush_clears, advance && job_ff.flush, column_ff == 8'd0, "column kept")
   `B64LW_ASSERT_NEXT(a_run_continues, advance && emit && !rsp_last_in, busy_ff, "run ended early")

endmodule
